@@ rtl/bsa_pkg.sv @@
`default_nettype none

package bsa_pkg;

  localparam logic [31:0] WindowReset = 32'h1000_0000;
  localparam logic [31:0] IoMask      = ~32'h3;
  localparam logic [31:0] MemMask     = ~32'hF;
  localparam logic [2:0]  TypeBits    = 3'h6;
  localparam logic [2:0]  TypeWide    = 3'h4;

  typedef struct packed {
    logic [31:0] probe_value;
    logic        new_device;
  } probe_item_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic        empty_slot;
    logic        is_io;
    logic        is_wide;
    logic [31:0] region_size;
    logic [63:0] bar_address;
    logic        address_valid;
    logic [2:0]  next_slot;
  } result_item_t;

  typedef struct packed {
    logic        new_device;
    logic        empty;
    logic        is_io;
    logic        is_wide;
    logic        size_nz;
    logic [31:0] size;
    logic [31:0] size_m1;
  } decode_t;

endpackage

`default_nettype wire

@@ rtl/bsa_decode.sv @@
`default_nettype none

module bsa_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire bsa_pkg::probe_item_t in_item_i,
  input  wire logic                advance_i,
  output      logic                dec_valid_o,
  output      bsa_pkg::decode_t    dec_o
);

  logic             valid_q;
  bsa_pkg::decode_t dec_q, dec_d;
  logic [31:0]      mask;
  logic             io;

  assign in_stall_o = valid_q && !advance_i;

  always_comb begin
    io   = in_item_i.probe_value[0];
    mask = io ? (in_item_i.probe_value & bsa_pkg::IoMask)
              : (in_item_i.probe_value & bsa_pkg::MemMask);
    dec_d.new_device = in_item_i.new_device;
    dec_d.empty      = (in_item_i.probe_value == 32'h0);
    dec_d.is_io      = io;
    dec_d.is_wide    = !io && ((in_item_i.probe_value[2:0] & bsa_pkg::TypeBits)
                               == bsa_pkg::TypeWide);
    dec_d.size_m1    = ~mask;
    dec_d.size       = ~mask + 32'h1;
    dec_d.size_nz    = (mask != 32'h0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_o       = dec_q;

endmodule

`default_nettype wire

@@ rtl/bsa_alloc.sv @@
`default_nettype none

module bsa_alloc #(
  parameter int unsigned BAR_SLOTS = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 dec_valid_i,
  input  wire bsa_pkg::decode_t     dec_i,
  output      logic                 advance_o,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      bsa_pkg::result_item_t out_item_o
);

  localparam logic [2:0] SlotsW = 3'(BAR_SLOTS);

  logic                  res_valid_q;
  bsa_pkg::result_item_t res_q, res_d;
  logic [63:0]           ptr_q, ptr_d;
  logic [2:0]            slot_q, slot_d;
  logic [2:0]            slot;
  logic [3:0]            sum;
  logic [63:0]           aligned;
  logic                  fire;

  assign advance_o = !res_valid_q || !out_stall_i;
  assign fire      = dec_valid_i && advance_o;

  always_comb begin
    slot    = dec_i.new_device ? 3'd0 : slot_q;
    res_d   = '0;
    ptr_d   = ptr_q;
    aligned = (ptr_q + {32'h0, dec_i.size_m1}) & ~{32'h0, dec_i.size_m1};
    sum     = {1'b0, slot} + ((!dec_i.empty && dec_i.is_wide) ? 4'd2 : 4'd1);
    if (slot >= SlotsW) begin
      res_d.slot      = SlotsW;
      res_d.next_slot = SlotsW;
    end else begin
      res_d.slot      = slot;
      res_d.next_slot = (sum > {1'b0, SlotsW}) ? SlotsW : sum[2:0];
      if (dec_i.empty) begin
        res_d.empty_slot = 1'b1;
      end else begin
        res_d.is_io       = dec_i.is_io;
        res_d.is_wide     = dec_i.is_wide;
        res_d.region_size = dec_i.size;
        if (!dec_i.is_io && dec_i.size_nz) begin
          res_d.bar_address   = aligned;
          res_d.address_valid = 1'b1;
          ptr_d               = aligned + {32'h0, dec_i.size};
        end
      end
    end
    slot_d = res_d.next_slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      ptr_q       <= {32'h0, bsa_pkg::WindowReset};
      slot_q      <= 3'd0;
    end else begin
      if (advance_o) begin
        res_valid_q <= dec_valid_i;
      end
      if (cfg_we_i) begin
        ptr_q <= {32'h0, cfg_data_i};
      end else if (fire) begin
        ptr_q <= ptr_d;
      end
      if (fire) begin
        slot_q <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule

`default_nettype wire

@@ rtl/pcie_bar_size_allocator_core.sv @@
// bar sizing and aligned allocation
// in channel: in_valid_i / in_stall_o carry one probe item (read-back bar
//   value and a first-bar-of-device flag); taken when valid and not stall
// out channel: out_valid_o / out_stall_i carry one result item per probe:
//   slot, decoded type, size, allocated address and the next slot
// cfg channel: cfg_valid_i / cfg_ready_o write the window base, which also
//   reloads the allocation pointer; ready is always high
// path: a probe passes through two register stages, the decode register and
//   then the result register
// throughput: one item per cycle while out_stall_i is low; the pointer and slot
//   counter update in the allocation stage, set by the align-and-bump adder
// reset: pointer loads 0x1000_0000, slot counter clears, no item in flight
// stall: a held result freezes the allocation stage; one decoded item waits
//   in the input register and in_stall_o rises only once that is full
`default_nettype none

module pcie_bar_size_allocator_core #(
  parameter int unsigned BAR_SLOTS = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [31:0]           cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire bsa_pkg::probe_item_t  in_item_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      bsa_pkg::result_item_t out_item_o
);

  logic             dec_valid;
  logic             advance;
  bsa_pkg::decode_t dec;

  assign cfg_ready_o = 1'b1;

  bsa_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .advance_i   (advance),
    .dec_valid_o (dec_valid),
    .dec_o       (dec)
  );

  bsa_alloc #(
    .BAR_SLOTS (BAR_SLOTS)
  ) u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .dec_valid_i (dec_valid),
    .dec_i       (dec),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
